// File: rtl/gnms_pkg.sv
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared widths, limits and control type of the greedy non-adjacent sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gnms_pkg;

   localparam int VALUE_W = 16;
   localparam int MAG_W   = VALUE_W - 1;
   localparam int TOTAL_W = 25;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/greedy_nonadjacent_max_sum_unit.sv
// ----------------------------------------------------------------------------
// greedy_nonadjacent_max_sum_unit
// Loads a set of signed values and returns the greedy non-adjacent max sum.
// ----------------------------------------------------------------------------
// Usage:
//   Present a request on req_value/req_last with start high; it is taken at a
//   clock edge where busy is low. Each request stores one value
//   (values past MAX_ITEMS are dropped). A request with req_last high closes
//   the set and starts the selection rounds; busy stays high until done.
//   Each round scans all n stored entries through one shared compare unit,
//   one entry per cycle from the value store's read port, then adds the
//   pick to the total and marks it and its neighbors blocked.
//   Picks are never adjacent, so there are at most (n + 1) / 2 of them.
//   A last round that finds nothing puts the total on rsp_total with
//   rsp_valid high for exactly one cycle, as busy drops.
//   The receiver cannot stall; it must take the response in that cycle.
//   The blocked map is rewritten to zero as each value loads, so entries
//   of an earlier set are never seen and no clearing pass is needed.
//   Reset empties the set, drops any work in flight and leaves busy low.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_nonadjacent_max_sum_unit import gnms_pkg::*; #(
   parameter int MAX_ITEMS = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output      logic                      busy,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic                      req_last,
   output      logic                      rsp_valid,
   output      logic [TOTAL_W-1:0]        rsp_total
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_BLK_L,
      ST_BLK_R
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [AW-1:0]      scan_addr_ff, scan_addr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic                      accept;
   logic                      has_room;
   logic                      val_wr_en;
   logic                      blk_wr_en;
   logic [AW-1:0]             blk_wr_addr;
   logic                      blk_wr_data;
   logic signed [VALUE_W-1:0] rd_value;
   logic                      rd_blocked;
   scan_ctrl_type             scan_ctrl;
   logic                      found;
   logic [MAG_W-1:0]          best;
   logic [AW-1:0]             pos;
   logic                      scan_at_end;
   logic [TOTAL_W:0]          sum;

   assign accept      = start && !busy;
   assign has_room    = count_ff < CW'(MAX_ITEMS);
   assign val_wr_en   = accept && has_room;
   assign scan_at_end = (CW'(scan_addr_ff) + CW'(1)) == n_ff;
   assign sum         = {1'b0, total_ff} + (TOTAL_W + 1)'(best);

   // ---- storage -----------------------------------------------------------
   gnms_mem #(
      .DEPTH (MAX_ITEMS),
      .AW    (AW)
   ) u_mem (
      .clock       (clock),
      .val_wr_en   (val_wr_en),
      .val_wr_addr (count_ff[AW-1:0]),
      .val_wr_data (req_value),
      .blk_wr_en   (blk_wr_en),
      .blk_wr_addr (blk_wr_addr),
      .blk_wr_data (blk_wr_data),
      .rd_addr     (scan_addr_ff),
      .rd_value    (rd_value),
      .rd_blocked  (rd_blocked)
   );

   // ---- shared compare unit -----------------------------------------------
   gnms_max_unit #(
      .AW (AW)
   ) u_max (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (scan_ctrl),
      .cand_value   (rd_value),
      .cand_blocked (rd_blocked),
      .cand_index   (rd_idx_ff),
      .found        (found),
      .best         (best),
      .pos          (pos)
   );

   // ---- sequencer ---------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      scan_addr_in  = scan_addr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = scan_addr_ff;
      total_in      = total_ff;
      rsp_valid_in  = 1'b0;
      rsp_total_in  = rsp_total_ff;
      blk_wr_en     = 1'b0;
      blk_wr_addr   = pos;
      blk_wr_data   = 1'b1;
      scan_ctrl     = '{clear: 1'b0, sample: rd_vld_ff};

      case (state_ff)
         ST_IDLE: begin
            // load: clear the blocked bit along with each stored value
            if (val_wr_en) begin
               blk_wr_en   = 1'b1;
               blk_wr_addr = count_ff[AW-1:0];
               blk_wr_data = 1'b0;
               count_in    = count_ff + CW'(1);
            end
            if (accept && req_last) begin
               n_in            = count_in;
               count_in        = '0;
               total_in        = '0;
               scan_addr_in    = '0;
               scan_ctrl.clear = 1'b1;
               state_in        = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read per cycle; the compare takes each read in the cycle after
            rd_vld_in = 1'b1;
            if (scan_at_end) begin
               state_in = ST_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (found) begin
               // add with saturation, block the pick itself
               total_in  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
               blk_wr_en = 1'b1;
               state_in  = ST_BLK_L;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_BLK_L: begin
            if (pos != '0) begin
               blk_wr_en   = 1'b1;
               blk_wr_addr = pos - AW'(1);
            end
            state_in = ST_BLK_R;
         end
         ST_BLK_R: begin
            if ((CW'(pos) + CW'(1)) < n_ff) begin
               blk_wr_en   = 1'b1;
               blk_wr_addr = pos + AW'(1);
            end
            scan_addr_in    = '0;
            scan_ctrl.clear = 1'b1;
            state_in        = ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      total_ff     <= total_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_total = rsp_total_ff;

   // ---- assertions --------------------------------------------------------
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response issued while still busy");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last) |=> busy)
      else $error("closing request did not start the rounds");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("stored count beyond capacity");

endmodule

`default_nettype wire

// File: rtl/gnms_mem.sv
// ----------------------------------------------------------------------------
// gnms_mem
// Value store and blocked map, one write port each and a shared registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_mem import gnms_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic                      clock,
   input  wire logic                      val_wr_en,
   input  wire logic [AW-1:0]             val_wr_addr,
   input  wire logic signed [VALUE_W-1:0] val_wr_data,
   input  wire logic                      blk_wr_en,
   input  wire logic [AW-1:0]             blk_wr_addr,
   input  wire logic                      blk_wr_data,
   input  wire logic [AW-1:0]             rd_addr,
   output      logic signed [VALUE_W-1:0] rd_value,
   output      logic                      rd_blocked
);

   logic signed [VALUE_W-1:0] value_mem [DEPTH];
   logic                      blk_mem   [DEPTH];

   // write value, read back registered
   always_ff @(posedge clock) begin
      if (val_wr_en) begin
         value_mem[val_wr_addr] <= val_wr_data;
      end
      rd_value <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (blk_wr_en) begin
         blk_mem[blk_wr_addr] <= blk_wr_data;
      end
      rd_blocked <= blk_mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/gnms_max_unit.sv
// ----------------------------------------------------------------------------
// gnms_max_unit
// Running maximum of unblocked non-negative values, lowest index on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_max_unit import gnms_pkg::*; #(
   parameter int AW = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire scan_ctrl_type             ctrl,
   input  wire logic signed [VALUE_W-1:0] cand_value,
   input  wire logic                      cand_blocked,
   input  wire logic [AW-1:0]             cand_index,
   output      logic                      found,
   output      logic [MAG_W-1:0]          best,
   output      logic [AW-1:0]             pos
);

   logic             found_ff;
   logic [MAG_W-1:0] best_ff;
   logic [AW-1:0]    pos_ff;
   logic             take;

   // strictly greater keeps the lowest index on a tie
   assign take = !cand_blocked && !cand_value[VALUE_W-1] &&
                 (!found_ff || (cand_value[MAG_W-1:0] > best_ff));

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (ctrl.sample && take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sample && take) begin
         best_ff <= cand_value[MAG_W-1:0];
         pos_ff  <= cand_index;
      end
   end

   assign found = found_ff;
   assign best  = best_ff;
   assign pos   = pos_ff;

endmodule

`default_nettype wire

// File: tb/sv/nonadjacent_sum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nonadjacent_sum_checker
// Watches the request and response channels of the greedy non-adjacent sum
// unit, predicts each set's total and compares it with the response.
// ----------------------------------------------------------------------------

module nonadjacent_sum_checker import gnms_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   input  logic                      rsp_valid,
   input  logic [TOTAL_W-1:0]        rsp_total,
   output int                        mismatch_count,
   output int                        totals_outstanding
);

   logic signed [VALUE_W-1:0] set_values [CAPACITY];
   int                        set_size;
   logic [TOTAL_W-1:0]        totals_due [$];
   logic [TOTAL_W-1:0]        expected_total;

   // Greedy rounds over the stored set: largest unblocked value >= 0,
   // lowest index on ties; block it and both neighbors.
   function automatic logic [TOTAL_W-1:0] greedy_pick_total();
      bit     blocked [CAPACITY];
      longint total;
      int     best;
      int     pos;
      total = 0;
      foreach (blocked[i]) blocked[i] = 1'b0;
      for (int round = 0; round < set_size; round++) begin
         best = -1;
         pos  = -1;
         for (int j = 0; j < set_size; j++) begin
            if (!blocked[j] && int'(set_values[j]) > best) begin
               best = set_values[j];
               pos  = j;
            end
         end
         if (pos < 0) break;
         total = total + best;
         if (total > TOTAL_MAX) total = TOTAL_MAX;
         blocked[pos] = 1'b1;
         if (pos > 0) blocked[pos-1] = 1'b1;
         if (pos + 1 < set_size) blocked[pos+1] = 1'b1;
      end
      return total[TOTAL_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         set_size = 0;
         totals_due.delete();
         mismatch_count = 0;
      end else begin
         // compare first, so a response never meets the total of a set
         // that closes at the same edge
         if (rsp_valid) begin
            if (totals_due.size() == 0) begin
               $error("total: expected none, actual %0d", rsp_total);
               mismatch_count++;
            end else begin
               expected_total = totals_due.pop_front();
               if (rsp_total !== expected_total) begin
                  $error("total: expected %0d, actual %0d", expected_total, rsp_total);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            if (set_size < CAPACITY) begin
               set_values[set_size] = req_value;
               set_size++;
            end
            if (req_last) begin
               totals_due.push_back(greedy_pick_total());
               set_size = 0;
            end
         end
      end
      totals_outstanding = totals_due.size();
   end

endmodule

// File: tb/sv/tb_greedy_nonadjacent_max_sum_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_greedy_nonadjacent_max_sum_unit
// Drives value sets into the greedy non-adjacent sum unit and gives the verdict.
// A short directed part covers extremes, ties, zeros, all-negative sets and
// capacity overflow; random sets of varied size and value mix follow, with
// random idle gaps on the request side. The checker beside the unit predicts
// and compares every total.
// ----------------------------------------------------------------------------

module tb_greedy_nonadjacent_max_sum_unit;
   import gnms_pkg::*;

   localparam int CAPACITY     = 1024;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int RANDOM_ITEMS = 750;
   localparam int TAIL_CYCLES  = 64;

   // value mixes for random sets
   typedef enum int {
      MIX_FULL,      // any 16-bit value
      MIX_TIES,      // small values around zero: many ties and zeros
      MIX_NEGATIVE,  // nothing selectable
      MIX_EXTREMES,  // only the corner values
      MIX_LARGE      // large positives: sums grow fast
   } value_mix_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic                      busy;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last  = 1'b0;
   logic                      rsp_valid;
   logic [TOTAL_W-1:0]        rsp_total;

   int mismatch_count;
   int totals_outstanding;
   int cycle_count = 0;
   int items_sent  = 0;
   bit steady      = 1'b0;  // set to suppress idle gaps on the request side

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   greedy_nonadjacent_max_sum_unit #(
      .MAX_ITEMS (CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_total (rsp_total)
   );

   nonadjacent_sum_checker #(
      .CAPACITY (CAPACITY)
   ) sum_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_total          (rsp_total),
      .mismatch_count     (mismatch_count),
      .totals_outstanding (totals_outstanding)
   );

   // Watchdog: end the run if the unit hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Present one request and hold it until the unit takes it. An optional
   // idle gap comes first; start drops only there, so it is never lowered
   // and raised in the same step.
   task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic is_last);
      if (!steady && $urandom_range(99) < 35) begin
         start <= 1'b0;
         if ($urandom_range(9) == 0) repeat ($urandom_range(30, 6)) @(posedge clock);
         else repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      req_last  <= is_last;
      // busy read right after the edge is its value at that edge
      do @(posedge clock); while (busy);
   endtask

   function automatic logic signed [VALUE_W-1:0] draw_value(input value_mix_type mix);
      case (mix)
         MIX_FULL:     return VALUE_W'($urandom);
         MIX_TIES:     return VALUE_W'(int'($urandom_range(8)) - 4);
         MIX_NEGATIVE: return VALUE_W'(-int'($urandom_range(32768, 1)));
         MIX_EXTREMES: begin
            case ($urandom_range(4))
               0:       return 16'sh8000;
               1:       return -16'sd1;
               2:       return 16'sd0;
               3:       return 16'sd1;
               default: return 16'sh7fff;
            endcase
         end
         default:      return VALUE_W'($urandom_range(32767, 16384));
      endcase
   endfunction

   // One well-formed set: size values, the last one marked.
   task automatic send_random_set(input int size, input value_mix_type mix);
      for (int k = 0; k < size; k++) begin
         send_value(draw_value(mix), k == size - 1);
         items_sent++;
      end
   endtask

   initial begin
      int            size;
      int            pick;
      value_mix_type mix;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Single-entry sets: largest value, most negative value, zero.
      send_value(16'sh7fff, 1'b1);
      send_value(16'sh8000, 1'b1);
      send_value(16'sd0, 1'b1);
      // Equal values: the lowest index wins, then the far one.
      send_value(16'sd5, 1'b0);
      send_value(16'sd5, 1'b0);
      send_value(16'sd5, 1'b1);
      // Greedy takes the middle and loses the better outer pair.
      send_value(16'sd3, 1'b0);
      send_value(16'sd4, 1'b0);
      send_value(16'sd3, 1'b1);
      // All negative: nothing selectable.
      send_value(-16'sd1, 1'b0);
      send_value(16'sh8000, 1'b0);
      send_value(-16'sd7, 1'b1);
      // Zeros are picked and block their neighbors without adding.
      send_value(16'sd7, 1'b0);
      send_value(16'sd0, 1'b0);
      send_value(16'sd0, 1'b0);
      send_value(16'sd0, 1'b1);
      // Largest values side by side.
      repeat (3) send_value(16'sh7fff, 1'b0);
      send_value(16'sh7fff, 1'b1);
      // Alternating extremes.
      send_value(16'sh8000, 1'b0);
      send_value(16'sh7fff, 1'b0);
      send_value(16'sh8000, 1'b0);
      send_value(16'sh7fff, 1'b0);
      send_value(16'sh8000, 1'b1);

      // Capacity overflow: fill the store, then two more large values that
      // must be dropped, the last of them closing the set. Keep most stored
      // values negative so the rounds stay few.
      for (int k = 0; k < CAPACITY + 2; k++) begin
         if (k >= CAPACITY - 1) send_value(16'sh7fff, k == CAPACITY + 1);
         else if (k % 64 == 0) send_value(VALUE_W'($urandom_range(32767)), 1'b0);
         else send_value(VALUE_W'(-int'($urandom_range(32768, 1))), 1'b0);
      end

      // Random sets: mostly small, some medium, a few wide. Hold off idle
      // gaps for a stretch in the middle.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         steady = (items_sent >= 300 && items_sent < 450);
         pick   = $urandom_range(99);
         if (pick < 70) size = $urandom_range(12, 1);
         else if (pick < 95) size = $urandom_range(40, 13);
         else size = $urandom_range(100, 41);
         mix = value_mix_type'($urandom_range(MIX_LARGE));
         send_random_set(size, mix);
      end

      // Drop start and let the checker take the last accepted request.
      start <= 1'b0;
      @(posedge clock);
      while (totals_outstanding != 0) @(posedge clock);
      // Give a stray response a chance to show up.
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && totals_outstanding == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
